FILE: hw/rtl/atlb_pkg.sv
`default_nettype none
package atlb_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int PAGE_BITS_DEF = 20;
    localparam int FRAME_BITS    = 20;
    localparam int TIME_BITS     = 31;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

    // top -> scan engine
    typedef struct packed {
        logic start;   // new item accepted this cycle
        logic take;    // finished result moves to the output register
    } t_ctl;

    // scan engine -> top
    typedef struct packed {
        logic idle;    // ready for a new item
        logic done;    // result fields valid
    } t_sts;

endpackage
`default_nettype wire

FILE: hw/rtl/atlb_mem.sv
`default_nettype none
module atlb_mem #(
    parameter int DEPTH = atlb_pkg::ENTRIES_DEF,
    parameter int WIDTH = atlb_pkg::PAGE_BITS_DEF + atlb_pkg::FRAME_BITS + atlb_pkg::TIME_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/atlb_scan.sv
`default_nettype none
module atlb_scan #(
    parameter int ENTRIES   = atlb_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS = atlb_pkg::PAGE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire atlb_pkg::t_ctl                   i_ctl,
    output atlb_pkg::t_sts                        o_sts,
    input  wire logic                             i_cmd,
    input  wire logic [PAGE_BITS-1:0]             i_page,
    input  wire logic [atlb_pkg::FRAME_BITS-1:0]  i_frame,
    input  wire logic [atlb_pkg::TIME_BITS-1:0]   i_time,
    output logic                                  o_hit,
    output logic      [$clog2(ENTRIES)-1:0]       o_slot,
    output logic      [atlb_pkg::FRAME_BITS-1:0]  o_frame
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int FW     = atlb_pkg::FRAME_BITS;
    localparam int TW     = atlb_pkg::TIME_BITS;
    localparam int WORD_W = PAGE_BITS + FW + TW;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    atlb_pkg::t_state r_state, n_state;

    logic [ENTRIES-1:0]   r_valid;
    logic                 r_cmd;
    logic [PAGE_BITS-1:0] r_page;
    logic [FW-1:0]        r_frame;
    logic [TW-1:0]        r_time;

    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_issue_done;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_cmp_vld;

    logic                 r_found;      // lookup match or empty entry seen
    logic [IDX_W-1:0]     r_hit_idx;
    logic [FW-1:0]        r_hit_frame;
    logic                 r_have;       // min tracker loaded
    logic [IDX_W-1:0]     r_min_idx;
    logic [TW-1:0]        r_min_time;

    logic                 w_rd_en;
    logic                 w_we;
    logic [WORD_W-1:0]    w_rdata;
    logic [PAGE_BITS-1:0] w_e_page;
    logic [FW-1:0]        w_e_frame;
    logic [TW-1:0]        w_e_time;
    logic                 w_e_valid;
    logic                 w_last;
    logic [IDX_W-1:0]     w_victim;

    atlb_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_victim),
        .i_wdata ({r_page, r_frame, r_time}),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    assign w_e_time  = w_rdata[TW-1:0];
    assign w_e_frame = w_rdata[TW +: FW];
    assign w_e_page  = w_rdata[TW+FW +: PAGE_BITS];
    assign w_e_valid = r_valid[r_cmp_idx];
    assign w_last    = r_cmp_vld && (r_cmp_idx == LAST_IDX);
    assign w_victim  = r_found ? r_hit_idx : r_min_idx;
    assign w_rd_en   = (r_state == atlb_pkg::ST_SCAN) && !r_issue_done;
    assign w_we      = (r_state == atlb_pkg::ST_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atlb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_sts   = '0;
        unique case (r_state)
            atlb_pkg::ST_IDLE: begin
                o_sts.idle = 1'b1;
                if (i_ctl.start) begin
                    n_state = atlb_pkg::ST_SCAN;
                end
            end
            atlb_pkg::ST_SCAN: begin
                if (w_last) begin
                    n_state = (r_cmd == atlb_pkg::CMD_INSERT) ? atlb_pkg::ST_WRITE
                                                              : atlb_pkg::ST_DONE;
                end
            end
            atlb_pkg::ST_WRITE: begin
                n_state = atlb_pkg::ST_DONE;
            end
            atlb_pkg::ST_DONE: begin
                o_sts.done = 1'b1;
                if (i_ctl.take) begin
                    n_state = atlb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = atlb_pkg::ST_IDLE;
            end
        endcase
    end

    // control bits and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_cmp_vld    <= 1'b0;
            r_issue_done <= 1'b0;
        end else begin
            r_cmp_vld <= w_rd_en;
            if (i_ctl.start && (r_state == atlb_pkg::ST_IDLE)) begin
                r_issue_done <= 1'b0;
            end else if (w_rd_en && (r_rd_idx == LAST_IDX)) begin
                r_issue_done <= 1'b1;
            end
            if (w_we) begin
                r_valid[w_victim] <= 1'b1;
            end
        end
    end

    // item capture, address sweep and compare
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_rd_idx;
        if (i_ctl.start && (r_state == atlb_pkg::ST_IDLE)) begin
            r_cmd    <= i_cmd;
            r_page   <= i_page;
            r_frame  <= i_frame;
            r_time   <= i_time;
            r_rd_idx <= '0;
            r_found  <= 1'b0;
            r_have   <= 1'b0;
        end else if (w_rd_en && (r_rd_idx != LAST_IDX)) begin
            r_rd_idx <= r_rd_idx + IDX_W'(1);
        end

        if (r_cmp_vld) begin
            if (r_cmd == atlb_pkg::CMD_LOOKUP) begin
                if (!r_found && w_e_valid && (w_e_page == r_page)) begin
                    r_found     <= 1'b1;
                    r_hit_idx   <= r_cmp_idx;
                    r_hit_frame <= w_e_frame;
                end
            end else begin
                priority if (!w_e_valid) begin
                    if (!r_found) begin
                        r_found   <= 1'b1;
                        r_hit_idx <= r_cmp_idx;
                    end
                end else if (!r_have || (w_e_time < r_min_time)) begin
                    r_have     <= 1'b1;
                    r_min_idx  <= r_cmp_idx;
                    r_min_time <= w_e_time;
                end else begin
                    // valid and not older than the current minimum: keep it
                end
            end
        end
    end

    always_comb begin
        if (r_cmd == atlb_pkg::CMD_INSERT) begin
            o_hit   = 1'b1;
            o_slot  = w_victim;
            o_frame = r_frame;
        end else begin
            o_hit   = r_found;
            o_slot  = r_found ? r_hit_idx : '0;
            o_frame = r_found ? r_hit_frame : '0;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/assoc_tlb_min_time_replace.sv
// Channel  | Dir | tuser (low bit up) | tdata (low bit up)
// ---------+-----+--------------------+---------------------------------------
// s (in)   | in  | cmd                | page, frame, time_stamp, 0 pad
// m (out)  | out | hit                | slot, frame_out, 0 pad
//
// One item at a time. Each item passes, in order, through the accept, a read of
// each entry through the single read port of the entry memory, one compare
// tail, the write-back on insert, and the handoff to the output reg.
// Synchronous active-low reset clears the valid flags; no clearing pass.
// A stalled result holds the engine done until the output register is free.
`default_nettype none
module assoc_tlb_min_time_replace #(
    parameter int ENTRIES   = atlb_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS = atlb_pkg::PAGE_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // input item
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    input  wire logic i_s_tuser,    // [0] cmd
    // page, frame, time_stamp from bit 0 up, zero padded to bytes
    input  wire logic [((PAGE_BITS + atlb_pkg::FRAME_BITS + atlb_pkg::TIME_BITS + 7) / 8) * 8 - 1:0]
                      i_s_tdata,
    // result item
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    output logic      o_m_tuser,    // [0] hit
    // slot, frame_out from bit 0 up, zero padded to bytes
    output logic [(($clog2(ENTRIES) + atlb_pkg::FRAME_BITS + 7) / 8) * 8 - 1:0]
                      o_m_tdata
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int FW      = atlb_pkg::FRAME_BITS;
    localparam int TW      = atlb_pkg::TIME_BITS;
    localparam int OUT_W   = (((IDX_W + FW) + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_W - (IDX_W + FW);

    atlb_pkg::t_ctl w_ctl;
    atlb_pkg::t_sts w_sts;

    logic             w_hit;
    logic [IDX_W-1:0] w_slot;
    logic [FW-1:0]    w_frame;
    logic             w_out_free;

    // output register
    logic             r_out_valid;
    logic             r_out_hit;
    logic [IDX_W-1:0] r_out_slot;
    logic [FW-1:0]    r_out_frame;

    assign o_s_tready = w_sts.idle;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_ctl.start = i_s_tvalid && w_sts.idle;
    assign w_ctl.take  = w_sts.done && w_out_free;

    atlb_scan #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .i_cmd   (i_s_tuser),
        .i_page  (i_s_tdata[PAGE_BITS-1:0]),
        .i_frame (i_s_tdata[PAGE_BITS +: FW]),
        .i_time  (i_s_tdata[PAGE_BITS+FW +: TW]),
        .o_hit   (w_hit),
        .o_slot  (w_slot),
        .o_frame (w_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.take) begin
            r_out_hit   <= w_hit;
            r_out_slot  <= w_slot;
            r_out_frame <= w_frame;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_hit;
    assign o_m_tdata  = {{OUT_PAD{1'b0}}, r_out_frame, r_out_slot};

    // an accepted item blocks a further accept in the cycle after it
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("accepted a second item while the scan was starting");

    // the engine never reports idle and done at once
    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_sts.idle && w_sts.done))
        else $error("scan engine idle and done together");

    // a handed-off result shows up on the output next cycle
    a_take_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.take |=> o_m_tvalid)
        else $error("result handoff lost");

    // a miss carries zero slot and zero frame
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> ((r_out_slot == '0) && (r_out_frame == '0)))
        else $error("miss result with nonzero slot or frame");

endmodule
`default_nettype wire

FILE: tb/tlb_translation_checker.sv
`default_nettype none
// Watches both streams of the translation buffer, keeps its own copy of the
// entry table and checks every result item against the predicted translation.
module tlb_translation_checker #(
    parameter int S_TDATA_W = 72,
    parameter int M_TDATA_W = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    input  wire logic                 i_s_tuser,    // [0] cmd
    // page, frame, time_stamp from bit 0 up, zero padded
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire logic                 i_m_tuser,    // [0] hit
    // slot, frame_out from bit 0 up, zero padded
    input  wire logic [M_TDATA_W-1:0] i_m_tdata,
    output int                        o_fail_count,
    output int                        o_outstanding
);

    localparam int ENTRIES    = atlb_pkg::ENTRIES_DEF;
    localparam int PAGE_W     = atlb_pkg::PAGE_BITS_DEF;
    localparam int FRAME_BITS = atlb_pkg::FRAME_BITS;
    localparam int TIME_BITS  = atlb_pkg::TIME_BITS;
    localparam int SLOT_W     = $clog2(ENTRIES);

    typedef struct packed {
        logic                  hit;
        logic [SLOT_W-1:0]     slot;
        logic [FRAME_BITS-1:0] frame;
    } t_xlat;

    logic                  tlb_valid [ENTRIES];
    logic [PAGE_W-1:0]     tlb_page  [ENTRIES];
    logic [FRAME_BITS-1:0] tlb_frame [ENTRIES];
    logic [TIME_BITS-1:0]  tlb_stamp [ENTRIES];

    t_xlat expected_xlats[$];
    int    mismatches = 0;

    assign o_fail_count = mismatches;

    // Applies one request to the shadow table and returns its translation.
    function automatic t_xlat translate(input logic cmd, input logic [PAGE_W-1:0] vpn,
                                        input logic [FRAME_BITS-1:0] pfn,
                                        input logic [TIME_BITS-1:0] stamp);
        t_xlat res;
        int    victim;
        res = '0;
        if (cmd == atlb_pkg::CMD_LOOKUP) begin
            // walk downward so the lowest matching index wins
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (tlb_valid[i] && tlb_page[i] == vpn) begin
                    res.hit   = 1'b1;
                    res.slot  = SLOT_W'(i);
                    res.frame = tlb_frame[i];
                end
            end
        end else begin
            victim = -1;
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!tlb_valid[i])
                    victim = i;
            end
            if (victim < 0) begin
                // table full: oldest stamp, ties to the lowest index
                victim = 0;
                for (int i = 1; i < ENTRIES; i++) begin
                    if (tlb_stamp[i] < tlb_stamp[victim])
                        victim = i;
                end
            end
            tlb_valid[victim] = 1'b1;
            tlb_page[victim]  = vpn;
            tlb_frame[victim] = pfn;
            tlb_stamp[victim] = stamp;
            res.hit   = 1'b1;
            res.slot  = SLOT_W'(victim);
            res.frame = pfn;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_xlat want;
        t_xlat got;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++)
                tlb_valid[i] = 1'b0;
            expected_xlats.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_xlats.push_back(translate(i_s_tuser, i_s_tdata[PAGE_W-1:0],
                    i_s_tdata[PAGE_W +: FRAME_BITS],
                    i_s_tdata[PAGE_W + FRAME_BITS +: TIME_BITS]));
            if (i_m_tvalid && i_m_tready) begin
                got.hit   = i_m_tuser;
                got.slot  = i_m_tdata[SLOT_W-1:0];
                got.frame = i_m_tdata[SLOT_W +: FRAME_BITS];
                if (expected_xlats.size() == 0) begin
                    $error("unexpected result item: hit %0d slot %0d frame_out 0x%05h",
                           got.hit, got.slot, got.frame);
                    mismatches++;
                end else begin
                    want = expected_xlats.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                        mismatches++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot: expected %0d, actual %0d", want.slot, got.slot);
                        mismatches++;
                    end
                    if (got.frame !== want.frame) begin
                        $error("frame_out: expected 0x%05h, actual 0x%05h",
                               want.frame, got.frame);
                        mismatches++;
                    end
                end
            end
        end
        o_outstanding <= expected_xlats.size();
    end

endmodule
`default_nettype wire

FILE: tb/assoc_tlb_min_time_replace_test.sv
`default_nettype none
// Stimulus and verdict for the translation buffer. The checker beside the
// block does all prediction; this module only drives items, paces the
// result side and decides pass or fail.
module assoc_tlb_min_time_replace_test;

    localparam int PAGE_W    = atlb_pkg::PAGE_BITS_DEF;
    localparam int FRAME_W   = atlb_pkg::FRAME_BITS;
    localparam int TIME_W    = atlb_pkg::TIME_BITS;
    localparam int SLOT_W    = $clog2(atlb_pkg::ENTRIES_DEF);
    localparam int S_TDATA_W = ((PAGE_W + FRAME_W + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SLOT_W + FRAME_W + 7) / 8) * 8;

    localparam int ITEMS_PER_PHASE = 185;
    localparam int POOL_DEPTH      = 128;   // twice the table, so evicted pages linger
    localparam int SETTLE_CYCLES   = 80;    // a bit over one insert scan
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no item moving on either side

    localparam logic [PAGE_W-1:0]  PAGE_ONES  = '1;
    localparam logic [FRAME_W-1:0] FRAME_ONES = '1;
    localparam logic [TIME_W-1:0]  STAMP_MAX  = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic                 s_tuser;     // [0] cmd
    logic [S_TDATA_W-1:0] s_tdata;     // page, frame, time_stamp, 0 pad
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 m_tuser;     // [0] hit
    logic [M_TDATA_W-1:0] m_tdata;     // slot, frame_out, 0 pad

    int fail_count;
    int outstanding;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles = 0;

    // pages already inserted; lookups and duplicate inserts draw from here
    logic [PAGE_W-1:0] known_pages[$];
    int unsigned       stamp_clock;

    assoc_tlb_min_time_replace dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tuser  (s_tuser),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tuser  (m_tuser),
        .o_m_tdata  (m_tdata)
    );

    tlb_translation_checker #(
        .S_TDATA_W (S_TDATA_W),
        .M_TDATA_W (M_TDATA_W)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tuser     (s_tuser),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tuser     (m_tuser),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: back-pressure drawn fresh every cycle.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a hung block stops both streams.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // One item: optional random idle cycles, then hold it until accepted.
    // tvalid gets one assignment per time step, so back-to-back items keep it high.
    task automatic send_item(input logic cmd, input logic [PAGE_W-1:0] vpn,
                             input logic [FRAME_W-1:0] pfn,
                             input logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({stamp, pfn, vpn});
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd == atlb_pkg::CMD_INSERT) begin
            known_pages.push_back(vpn);
            if (known_pages.size() > POOL_DEPTH)
                void'(known_pages.pop_front());
        end
    endtask

    // Stop sending and wait until every predicted result has come back.
    // The extra edge lets the checker count the item accepted last.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Random item: lookups mostly draw on known pages, inserts mostly bring new
    // pages. Stamps mix a rising clock (plain oldest-first eviction), a tiny
    // range (many ties on the smallest stamp), the extremes and full noise.
    task automatic send_random_item();
        logic              cmd;
        logic [PAGE_W-1:0] vpn;
        logic [TIME_W-1:0] stamp;
        int                reuse_pct;
        int                mode;
        cmd       = 1'($urandom_range(1));
        reuse_pct = (cmd == atlb_pkg::CMD_INSERT) ? 20 : 75;
        vpn       = PAGE_W'($urandom);
        if ($urandom_range(99) < 5) begin
            vpn = $urandom_range(1) ? PAGE_ONES : '0;
        end else if (known_pages.size() != 0 && $urandom_range(99) < reuse_pct) begin
            vpn = known_pages[$urandom_range(known_pages.size() - 1)];
        end
        mode = int'($urandom_range(9));
        if (mode < 4) begin
            stamp_clock += $urandom_range(1, 1000);
            stamp = stamp_clock[TIME_W-1:0];
        end else if (mode < 7) begin
            stamp = TIME_W'($urandom_range(15));
        end else if (mode == 7) begin
            stamp = $urandom_range(1) ? STAMP_MAX : '0;
        end else begin
            stamp = TIME_W'($urandom);
        end
        send_item(cmd, vpn, FRAME_W'($urandom), stamp);
    endtask

    initial begin
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tuser        <= atlb_pkg::CMD_LOOKUP;
        s_tdata        <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stamp_clock    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: misses on an empty table (frame and stamp of a lookup
        // are don't-care, so drive them all ones), field extremes, a
        // duplicate page that must resolve to the lower slot, and
        // alternating bit patterns.
        send_item(atlb_pkg::CMD_LOOKUP, '0, FRAME_ONES, STAMP_MAX);
        send_item(atlb_pkg::CMD_LOOKUP, PAGE_ONES, FRAME_ONES, STAMP_MAX);
        send_item(atlb_pkg::CMD_INSERT, '0, FRAME_ONES, STAMP_MAX);
        send_item(atlb_pkg::CMD_INSERT, PAGE_ONES, '0, '0);
        send_item(atlb_pkg::CMD_INSERT, '0, 20'h12345, '0);
        send_item(atlb_pkg::CMD_LOOKUP, '0, '0, '0);
        send_item(atlb_pkg::CMD_LOOKUP, PAGE_ONES, FRAME_ONES, STAMP_MAX);
        send_item(atlb_pkg::CMD_LOOKUP, 20'h55555, '0, '0);
        send_item(atlb_pkg::CMD_INSERT, 20'hAAAAA, 20'h55555, 31'h2AAAAAAA);
        send_item(atlb_pkg::CMD_INSERT, 20'h55555, 20'hAAAAA, 31'h55555555);
        send_item(atlb_pkg::CMD_LOOKUP, 20'hAAAAA, '0, '0);
        send_item(atlb_pkg::CMD_LOOKUP, 20'h55555, '0, '0);
        send_item(atlb_pkg::CMD_LOOKUP, 20'h00001, '0, '0);
        drain();

        // Random phases: no idling, sender idle, receiver stalls, both.
        // Each phase ends with a full drain.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 69 : (phase == 3) ? 18 : 0;
            recv_stall_pct = (phase == 2) ? 69 : (phase == 3) ? 18 : 0;
            repeat (ITEMS_PER_PHASE)
                send_random_item();
            drain();
        end

        // Any stray result would show up here.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
